[src/card_whitelist_enroll_controller_macros.svh]
// ----------------------------------------------------------------------------
// card whitelist enroll controller assertion macros
// shared property wrappers, clocked on clk_i with reset disable
// ----------------------------------------------------------------------------
`ifndef CARD_WHITELIST_ENROLL_CONTROLLER_MACROS_SVH
`define CARD_WHITELIST_ENROLL_CONTROLLER_MACROS_SVH

// same-cycle implication
`define CWE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cwe check failed");

// next-cycle implication
`define CWE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cwe check failed");

`endif

[src/cwe_pkg.sv]
// ----------------------------------------------------------------------------
// cwe_pkg
// shared constants and types of the card whitelist enroll controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cwe_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ID_W        = 40;
  localparam int SLOT_W      = 6;
  localparam int STATUS_W    = 4;
  localparam int MODE_W      = 2;
  localparam int OUT_W       = 16;

  localparam logic [ID_W-1:0] EMPTY_ID     = {ID_W{1'b1}};
  localparam logic [ID_W-1:0] MASTER_RESET = 40'h43_5844_2D72;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_AFTER  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED     = 4'd0,
    ST_DENIED      = 4'd1,
    ST_ADDED       = 4'd2,
    ST_ALREADY     = 4'd3,
    ST_FULL        = 4'd4,
    ST_REMOVED     = 4'd5,
    ST_NOT_ENROLL  = 4'd6,
    ST_TO_ADD      = 4'd7,
    ST_TO_REMOVE   = 4'd8,
    ST_TO_AFTER    = 4'd9,
    ST_TO_NORMAL   = 4'd10
  } status_e;

  // scan token walking down the chain
  typedef struct packed {
    logic             vld;
    logic [ID_W-1:0]  id;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             emp;
    logic [IDX_W-1:0] emp_idx;
  } cwe_tok_t;

  // table write broadcast
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [ID_W-1:0]  data;
  } cwe_wr_t;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

[src/cwe_cell.sv]
// ----------------------------------------------------------------------------
// cwe_cell
// one table slot: holds an id, compares the passing token, forwards it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwe_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [cwe_pkg::IDX_W-1:0] cell_idx_i,
  input  cwe_pkg::cwe_tok_t      tok_i,
  output cwe_pkg::cwe_tok_t      tok_o,
  input  cwe_pkg::cwe_wr_t       wr_i
);
  import cwe_pkg::*;

  logic [ID_W-1:0] entry_q;
  logic            tok_vld_q;
  cwe_tok_t        tok_d;
  cwe_tok_t        tok_q;

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.hit && (entry_q == tok_i.id)) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_idx = cell_idx_i;
    end
    if (!tok_i.emp && (entry_q == EMPTY_ID)) begin
      tok_d.emp     = 1'b1;
      tok_d.emp_idx = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q   <= EMPTY_ID;
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_i.vld;
      if (wr_i.en && (wr_i.idx == cell_idx_i)) begin
        entry_q <= wr_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = tok_vld_q;
  end

endmodule

[src/cwe_chain.sv]
// ----------------------------------------------------------------------------
// cwe_chain
// row of table cells the scan token walks through, one cell per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwe_chain (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cwe_pkg::cwe_tok_t head_i,
  output cwe_pkg::cwe_tok_t tail_o,
  input  cwe_pkg::cwe_wr_t  wr_i
);
  import cwe_pkg::*;

  cwe_tok_t link [TABLE_DEPTH+1];

  assign link[0] = head_i;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    cwe_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .tok_i      (link[g]),
      .tok_o      (link[g+1]),
      .wr_i       (wr_i)
    );
  end

  assign tail_o = link[TABLE_DEPTH];

endmodule

[src/card_whitelist_enroll_controller.sv]
// result: registered in out_q once the chain tail has been captured in res_q
// cards: one at a time, taken in idle after the last result is loaded; the token walks
//   the cell chain one slot per cycle; a waiting result stalls only the final step
// reset: mode returns to normal, every slot reads empty, master id takes its default
// ----------------------------------------------------------------------------
// card_whitelist_enroll_controller
// checks presented card ids against a master id and an enrolled table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module card_whitelist_enroll_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [39:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [39:0] card_id
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [3:0] status, [5:4] mode_after, [11:6] slot
);
  import cwe_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_e;

  state_e            state_q;
  mode_e             mode_q, mode_d;
  logic [ID_W-1:0]   master_q;
  logic [ID_W-1:0]   card_q;
  cwe_tok_t          res_q;
  logic              out_vld_q;
  logic [OUT_W-1:0]  out_q;
  cwe_tok_t          head;
  cwe_tok_t          tail;
  cwe_wr_t           wr;
  status_e           status_d;
  logic [SLOT_W-1:0] slot_d;
  logic              load;
  logic              in_xfer;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign load          = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);

  always_comb begin
    head         = '0;
    head.vld     = in_xfer;
    head.id      = s_axis_tdata;
  end

  cwe_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .tail_o (tail),
    .wr_i   (wr)
  );

  always_comb begin
    mode_d   = mode_q;
    status_d = ST_DENIED;
    slot_d   = '0;
    wr       = '0;
    wr.data  = card_q;
    if (card_q == master_q) begin
      unique case (mode_q)
        MODE_NORMAL: begin
          mode_d   = MODE_ADD;
          status_d = ST_TO_ADD;
        end
        MODE_ADD: begin
          mode_d   = MODE_REMOVE;
          status_d = ST_TO_REMOVE;
        end
        MODE_REMOVE: begin
          mode_d   = MODE_AFTER;
          status_d = ST_TO_AFTER;
        end
        default: begin
          mode_d   = MODE_NORMAL;
          status_d = ST_TO_NORMAL;
        end
      endcase
    end else if (mode_q == MODE_ADD) begin
      if (res_q.hit) begin
        status_d = ST_ALREADY;
        slot_d   = to_slot(res_q.hit_idx);
      end else if (res_q.emp) begin
        status_d = ST_ADDED;
        slot_d   = to_slot(res_q.emp_idx);
        wr.en    = load;
        wr.idx   = res_q.emp_idx;
      end else begin
        status_d = ST_FULL;
      end
    end else if (mode_q == MODE_REMOVE) begin
      if (res_q.hit) begin
        status_d = ST_REMOVED;
        slot_d   = to_slot(res_q.hit_idx);
        wr.en    = load;
        wr.idx   = res_q.hit_idx;
        wr.data  = EMPTY_ID;
      end else begin
        status_d = ST_NOT_ENROLL;
      end
    end else begin
      if (res_q.hit) begin
        status_d = ST_GRANTED;
        slot_d   = to_slot(res_q.hit_idx);
      end else begin
        status_d = ST_DENIED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= MODE_NORMAL;
      master_q  <= MASTER_RESET;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        master_q <= cfg_wdata_i;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tail.vld) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state_q   <= S_IDLE;
            mode_q    <= mode_d;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      card_q <= s_axis_tdata;
    end
    if (state_q == S_SCAN && tail.vld) begin
      res_q <= tail;
    end
    if (load) begin
      out_q <= {4'b0000, slot_d, mode_d, status_d};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  `include "card_whitelist_enroll_controller_macros.svh"

  `CWE_ASSERT_SAME(a_tail_only_in_scan, tail.vld, state_q == S_SCAN)
  `CWE_ASSERT_NEXT(a_xfer_starts_scan, in_xfer, state_q == S_SCAN)
  `CWE_ASSERT_NEXT(a_load_shows_result, load, m_axis_tvalid && (m_axis_tdata[5:4] == mode_q))
  `CWE_ASSERT_SAME(a_write_only_on_load, wr.en, load)

endmodule
